// File: src/u8cc_pkg.sv
`default_nettype none

package u8cc_pkg;

  // Counter widths of the position trackers.
  localparam int unsigned LINE_BITS   = 20;
  localparam int unsigned COLUMN_BITS = 16;

  // Character kind codes; 1 to 5 name sequences of 2 to 6 bytes.
  localparam logic [2:0] KIND_ASCII = 3'd0;
  localparam logic [2:0] KIND_ERROR = 3'd6;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [1:0] CONT_TAG     = 2'b10;

  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [COLUMN_BITS-1:0] column_t;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [2:0] owed_continuations;
    logic [2:0] pending_kind;
    line_t      line_count;
    column_t    column_count;
  } dec_state_t;

  // One result word.
  typedef struct packed {
    logic [2:0] char_kind;
    logic [6:0] ascii_value;
    line_t      line_number;
    column_t    column_number;
  } char_word_t;

endpackage

`default_nettype wire

// File: src/u8cc_byte_if.sv
`default_nettype none

interface u8cc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: src/u8cc_char_if.sv
`default_nettype none

interface u8cc_char_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           char_kind;
  logic [6:0]           ascii_value;
  u8cc_pkg::line_t      line_number;
  u8cc_pkg::column_t    column_number;

  modport source (output valid, output char_kind, output ascii_value,
                  output line_number, output column_number, input ready);
  modport sink (input valid, input char_kind, input ascii_value,
                input line_number, input column_number, output ready);
endinterface

`default_nettype wire

// File: src/u8cc_step.sv
`default_nettype none

module u8cc_step (
  input  wire u8cc_pkg::dec_state_t state,
  input  wire logic [7:0]           in_byte,
  output u8cc_pkg::dec_state_t      state_next,
  output logic                      has_result,
  output u8cc_pkg::char_word_t      result
);

  logic       is_cont;
  logic [2:0] owed_dec;
  logic [2:0] need;
  logic       line_sat;
  logic       column_sat;

  assign is_cont    = (in_byte[7:6] == u8cc_pkg::CONT_TAG);
  assign owed_dec   = state.owed_continuations - 3'd1;
  assign line_sat   = (state.line_count == {u8cc_pkg::LINE_BITS{1'b1}});
  assign column_sat = (state.column_count == {u8cc_pkg::COLUMN_BITS{1'b1}});

  // Number of continuation bytes a lead byte announces; zero for a bad lead.
  always_comb begin
    if (in_byte inside {[8'hC0:8'hDF]}) begin
      need = 3'd1;
    end else if (in_byte inside {[8'hE0:8'hEF]}) begin
      need = 3'd2;
    end else if (in_byte inside {[8'hF0:8'hF7]}) begin
      need = 3'd3;
    end else if (in_byte inside {[8'hF8:8'hFB]}) begin
      need = 3'd4;
    end else if (in_byte inside {[8'hFC:8'hFD]}) begin
      need = 3'd5;
    end else begin
      need = 3'd0;
    end
  end

  // Sequence tracking and position update for one byte.
  always_comb begin
    state_next         = state;
    has_result         = 1'b0;
    result.char_kind   = u8cc_pkg::KIND_ASCII;
    result.ascii_value = 7'd0;
    if (state.owed_continuations != 3'd0) begin
      if (!is_cont) begin
        state_next.owed_continuations = 3'd0;
        state_next.pending_kind       = 3'd0;
        has_result                    = 1'b1;
        result.char_kind              = u8cc_pkg::KIND_ERROR;
      end else begin
        state_next.owed_continuations = owed_dec;
        if (owed_dec == 3'd0) begin
          if (!column_sat) begin
            state_next.column_count = state.column_count + u8cc_pkg::column_t'(1);
          end
          state_next.pending_kind = 3'd0;
          has_result              = 1'b1;
          result.char_kind        = state.pending_kind;
        end
      end
    end else if (!in_byte[7]) begin
      if (in_byte == u8cc_pkg::NEWLINE_BYTE) begin
        if (!line_sat) begin
          state_next.line_count = state.line_count + u8cc_pkg::line_t'(1);
        end
        state_next.column_count = u8cc_pkg::column_t'(1);
      end else if (!column_sat) begin
        state_next.column_count = state.column_count + u8cc_pkg::column_t'(1);
      end
      has_result         = 1'b1;
      result.ascii_value = in_byte[6:0];
    end else if (need == 3'd0) begin
      has_result       = 1'b1;
      result.char_kind = u8cc_pkg::KIND_ERROR;
    end else begin
      state_next.owed_continuations = need;
      state_next.pending_kind       = need;
    end
    // The reported position is the one after the byte; errors leave it as is.
    result.line_number   = state_next.line_count;
    result.column_number = state_next.column_count;
  end

endmodule

`default_nettype wire

// File: src/utf8_char_classifier_line_col_core.sv
`default_nettype none

// A result word is registered in the output register once the byte that completes it is
// accepted, unless the sink still holds the output register, when it waits in the skid register.
// Throughput: one byte per cycle while ready is high; the decode and position update fit
// between state and output registers; a skid register takes a word while the sink stalls.
// Ready drops only while the skid register holds a word.
// Reset (synchronous, rst high): line and column return to 1, no sequence pending, output empty.
module utf8_char_classifier_line_col_core (
  input  wire logic  clk,
  input  wire logic  rst,
  u8cc_byte_if.sink  byte_ch,
  u8cc_char_if.source char_ch
);

  u8cc_pkg::dec_state_t state;
  u8cc_pkg::dec_state_t state_next;
  u8cc_pkg::char_word_t step_word;
  u8cc_pkg::char_word_t out_word;
  u8cc_pkg::char_word_t skid_word;
  logic                 has_result;
  logic                 out_valid;
  logic                 skid_valid;
  logic                 take;
  logic                 push;
  logic                 pop;

  u8cc_step u_step (
    .state      (state),
    .in_byte    (byte_ch.in_byte),
    .state_next (state_next),
    .has_result (has_result),
    .result     (step_word)
  );

  assign byte_ch.ready = !skid_valid;
  assign take          = byte_ch.valid && !skid_valid;
  assign push          = take && has_result;
  assign pop           = out_valid && char_ch.ready;

  // Decoder state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.owed_continuations <= 3'd0;
      state.pending_kind       <= 3'd0;
      state.line_count         <= u8cc_pkg::line_t'(1);
      state.column_count       <= u8cc_pkg::column_t'(1);
    end else if (take) begin
      state <= state_next;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_word  <= step_word;
        skid_valid <= 1'b1;
      end else begin
        out_word  <= step_word;
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign char_ch.valid         = out_valid;
  assign char_ch.char_kind     = out_word.char_kind;
  assign char_ch.ascii_value   = out_word.ascii_value;
  assign char_ch.line_number   = out_word.line_number;
  assign char_ch.column_number = out_word.column_number;

  // The skid register is only filled behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  // No more than five continuations are ever owed.
  a_owed_range: assert property (@(posedge clk) disable iff (rst)
    state.owed_continuations <= 3'd5)
    else $error("owed continuation count out of range");

  // Line and column never fall to zero.
  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state.line_count != '0) && (state.column_count != '0))
    else $error("position counter reached zero");

  // After a byte that yields a result word is accepted, the output register holds a valid word on the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("result word lost");

  // A pending kind exists exactly while continuations are owed.
  a_pending_match: assert property (@(posedge clk) disable iff (rst)
    (state.owed_continuations == 3'd0) == (state.pending_kind == 3'd0))
    else $error("pending kind out of step with owed count");

endmodule

`default_nettype wire
